@@ rtl/gxy_pkg.sv @@
// Shared types and constants for the galvo XY to DAC code converter.
// Used by every module in rtl/; depends on nothing.
package gxy_pkg;

  localparam int DAC_BITS   = 12;
  localparam int FRAC_BITS  = 14;
  localparam int LEN_W      = 24;
  localparam int LIM_W      = 15;
  localparam int ROOT_W     = 25;
  localparam int SQ_W       = 49;
  localparam int DEN_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_DIST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_SP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_MAX   = 3'd3;

  localparam logic [LEN_W-1:0] PLANE_DIST_RST = 24'd200000;
  localparam logic [LEN_W-1:0] MIRROR_SP_RST  = 24'd10000;
  localparam logic [LIM_W-1:0] ALPHA_MAX_RST  = 15'd5734;
  localparam logic [LIM_W-1:0] BETA_MAX_RST   = 15'd5734;

  typedef struct packed {
    logic signed [LEN_W-1:0] x_pos;
    logic signed [LEN_W-1:0] y_pos;
  } in_t;

  typedef struct packed {
    logic [DAC_BITS-1:0] alpha_code;
    logic [DAC_BITS-1:0] beta_code;
    logic                clipped;
  } out_t;

  // Item data carried alongside the square-root pipeline
  typedef struct packed {
    logic signed [LEN_W-1:0] x;
    logic signed [LEN_W-1:0] y;
    logic [LEN_W-1:0]        plane_d;
    logic [LEN_W-1:0]        spacing;
    logic [LIM_W-1:0]        amax;
    logic [LIM_W-1:0]        bmax;
  } side_t;

  // One arctangent-to-code job
  typedef struct packed {
    logic             neg;
    logic [LEN_W-1:0] mag;
    logic [DEN_W-1:0] den;
    logic [LIM_W-1:0] lim;
  } at_in_t;

  typedef struct packed {
    logic [DAC_BITS-1:0] code;
    logic                clip;
  } at_out_t;

  // Pipeline handshake between top level and its units
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

@@ rtl/gxy_isqrt.sv @@
// Pipelined floor integer square root, one root bit per stage, with side data.
// Depends on gxy_pkg.
module gxy_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gxy_pkg::pipe_ctl_t           ctl,
  input  logic [gxy_pkg::SQ_W-1:0]     n_in,
  input  gxy_pkg::side_t               side_in,
  output logic                         vld_out,
  output logic [gxy_pkg::ROOT_W-1:0]   root_out,
  output gxy_pkg::side_t               side_out
);

  localparam int NS   = gxy_pkg::ROOT_W;
  localparam int PADW = 2 * NS;
  localparam int REMW = gxy_pkg::ROOT_W + 2;

  logic [PADW-1:0]             nsh_r  [0:NS];
  logic [REMW-1:0]             rem_r  [0:NS];
  logic [gxy_pkg::ROOT_W-1:0]  root_r [0:NS];
  gxy_pkg::side_t              side_r [0:NS];
  logic                        v_r    [0:NS];

  always_comb begin
    nsh_r[0]  = {{(PADW-gxy_pkg::SQ_W){1'b0}}, n_in};
    rem_r[0]  = '0;
    root_r[0] = '0;
    side_r[0] = side_in;
    v_r[0]    = ctl.vld;
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [REMW+1:0] remw;
    logic [REMW+1:0] trial;
    logic            ge;

    always_comb begin
      remw  = {rem_r[i], nsh_r[i][PADW-1:PADW-2]};
      trial = {2'b00, root_r[i], 2'b01};
      ge    = remw >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (ctl.en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        nsh_r[i+1]  <= {nsh_r[i][PADW-3:0], 2'b00};
        rem_r[i+1]  <= ge ? REMW'(remw - trial) : REMW'(remw);
        root_r[i+1] <= {root_r[i][gxy_pkg::ROOT_W-2:0], ge};
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign vld_out  = v_r[NS];
  assign root_out = root_r[NS];
  assign side_out = side_r[NS];

endmodule

@@ rtl/gxy_atan_code.sv @@
// Pade arctangent of mag/den in Q2.14 and its conversion to a saturated DAC code.
// Depends on gxy_pkg; long divisions run one quotient bit per stage.
module gxy_atan_code (
  input  logic               clk,
  input  logic               rst_n,
  input  gxy_pkg::pipe_ctl_t ctl,
  input  gxy_pkg::at_in_t    job_in,
  output logic               vld_out,
  output gxy_pkg::at_out_t   res_out
);

  localparam int QB   = gxy_pkg::FRAC_BITS;
  localparam int CB   = gxy_pkg::DAC_BITS;
  localparam int LW   = gxy_pkg::LEN_W;
  localparam int DW   = gxy_pkg::DEN_W;
  localparam int MDW  = LW + DW;
  localparam int MMW  = 2 * LW;
  localparam int DDW  = 2 * DW;
  localparam int BOTW = DDW + 2;
  localparam int TOPW = 64;
  localparam int SHW  = BOTW + QB - 1;
  localparam int TW   = gxy_pkg::LIM_W + 2;
  localparam int MW   = gxy_pkg::LIM_W + 1;

  typedef struct packed {
    logic                      neg;
    logic                      zero;
    logic [gxy_pkg::LIM_W-1:0] lim;
    logic [BOTW-1:0]           bot;
  } dv_side_t;

  // Products
  logic [MDW-1:0] md_r;
  logic [MMW-1:0] mm_r;
  logic [DDW-1:0] dd_r;
  logic           a1_neg_r;
  logic [gxy_pkg::LIM_W-1:0] a1_lim_r;
  logic           a1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_v_r <= 1'b0;
    end else if (ctl.en) begin
      a1_v_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      md_r     <= MDW'(job_in.mag) * MDW'(job_in.den);
      mm_r     <= MMW'(job_in.mag) * MMW'(job_in.mag);
      dd_r     <= DDW'(job_in.den) * DDW'(job_in.den);
      a1_neg_r <= job_in.neg;
      a1_lim_r <= job_in.lim;
    end
  end

  // Numerator and denominator of the ratio
  logic [TOPW-1:0] top_nxt;
  logic [BOTW-1:0] bot_nxt;

  always_comb begin
    top_nxt = TOPW'({(MDW'(md_r) + {md_r[MDW-2:0], 1'b0}), {QB{1'b0}}});
    bot_nxt = BOTW'(mm_r) + BOTW'(dd_r) + {1'b0, dd_r, 1'b0};
  end

  logic [TOPW-1:0] rem_r  [0:QB];
  logic [QB-1:0]   q_r    [0:QB];
  dv_side_t        dvs_r  [0:QB];
  logic            dv_v_r [0:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (ctl.en) begin
      dv_v_r[0] <= a1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem_r[0]      <= top_nxt;
      q_r[0]        <= '0;
      dvs_r[0].neg  <= a1_neg_r;
      dvs_r[0].zero <= (mm_r == '0) && (dd_r == '0);
      dvs_r[0].lim  <= a1_lim_r;
      dvs_r[0].bot  <= bot_nxt;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_qdiv
    localparam int K = QB - 1 - i;
    logic [SHW-1:0] shb;
    logic           ge;

    always_comb begin
      shb = SHW'(dvs_r[i].bot) << K;
      ge  = SHW'(rem_r[i]) >= shb;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i+1] <= 1'b0;
      end else if (ctl.en) begin
        dv_v_r[i+1] <= dv_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[i+1] <= ge ? TOPW'(SHW'(rem_r[i]) - shb) : rem_r[i];
        q_r[i+1]   <= {q_r[i][QB-2:0], ge};
        dvs_r[i+1] <= dvs_r[i];
      end
    end
  end

  // Signed angle plus limit
  logic [QB-1:0]             qf;
  logic signed [QB:0]        ang;
  logic [gxy_pkg::LIM_W-1:0] lim1;
  logic signed [TW-1:0]      t_nxt;
  logic signed [TW-1:0]      t_r;
  logic [MW-1:0]             m2_r;
  logic                      a3_v_r;

  always_comb begin
    qf    = dvs_r[QB].zero ? '0 : q_r[QB];
    ang   = dvs_r[QB].neg ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
    lim1  = (dvs_r[QB].lim == '0) ? gxy_pkg::LIM_W'(1) : dvs_r[QB].lim;
    t_nxt = TW'(ang) + $signed(TW'(lim1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a3_v_r <= 1'b0;
    end else if (ctl.en) begin
      a3_v_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      t_r  <= t_nxt;
      m2_r <= {lim1, 1'b0};
    end
  end

  // Classify range, seed the code division
  logic          under_nxt;
  logic          over_nxt;
  logic [MW-1:0] crem_r  [0:CB];
  logic [CB-1:0] code_r  [0:CB];
  logic [MW-1:0] cm2_r   [0:CB];
  logic          under_r [0:CB];
  logic          over_r  [0:CB];
  logic          cv_r    [0:CB];

  always_comb begin
    under_nxt = t_r[TW-1];
    over_nxt  = !under_nxt && (t_r[MW-1:0] >= m2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (ctl.en) begin
      cv_r[0] <= a3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      under_r[0] <= under_nxt;
      over_r[0]  <= over_nxt;
      crem_r[0]  <= (under_nxt || over_nxt) ? '0 : t_r[MW-1:0];
      code_r[0]  <= '0;
      cm2_r[0]   <= m2_r;
    end
  end

  for (genvar j = 0; j < CB; j++) begin : g_cdiv
    logic [MW:0] remw;
    logic        ge;

    always_comb begin
      remw = {crem_r[j], 1'b0};
      ge   = remw >= {1'b0, cm2_r[j]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[j+1] <= 1'b0;
      end else if (ctl.en) begin
        cv_r[j+1] <= cv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        crem_r[j+1]  <= ge ? MW'(remw - {1'b0, cm2_r[j]}) : MW'(remw);
        code_r[j+1]  <= {code_r[j][CB-2:0], ge};
        cm2_r[j+1]   <= cm2_r[j];
        under_r[j+1] <= under_r[j];
        over_r[j+1]  <= over_r[j];
      end
    end
  end

  assign vld_out      = cv_r[CB];
  assign res_out.code = under_r[CB] ? '0 : (over_r[CB] ? '1 : code_r[CB]);
  assign res_out.clip = under_r[CB] || over_r[CB];

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    a3_v_r |-> (t_r <= $signed(TW'(32'd49150)))) else $error("angle sum out of range");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r[0] |-> !(under_r[0] && over_r[0])) else $error("under and over both set");
  a_under_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cv_r[CB] && under_r[CB]) |-> (res_out.code == '0 && res_out.clip))
    else $error("code below range not held at zero");

endmodule

@@ rtl/galvo_xy_to_dac_codes.sv @@
// Top level of the galvo XY to DAC code converter: config registers, squares,
// square root (gxy_isqrt) and two arctangent/code units (gxy_atan_code).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in_     | input     | in_valid / in_stall  | gxy_pkg::in_t (x_pos, y_pos)
//   out_    | output    | out_valid / out_stall| gxy_pkg::out_t (codes, clipped)
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction enters per cycle while in_stall is low; it passes 60 register
// stages: the 25-stage root pipeline, the 14 + 12 stage long divisions inside
// each arctangent unit and nine single stages for capture, squares, sums,
// products and the output. Reset (synchronous, rst_n low) clears every valid
// bit and loads the config defaults. A stall while out_valid is high freezes
// the whole pipeline together with the output register, so the input stalls
// in the same cycle; nothing is dropped.
module galvo_xy_to_dac_codes (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  gxy_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output gxy_pkg::out_t                    out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gxy_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gxy_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LW = gxy_pkg::LEN_W;

  // Config registers; always ready, unknown indices are dropped
  logic [LW-1:0]             plane_dist_r;
  logic [LW-1:0]             mirror_sp_r;
  logic [gxy_pkg::LIM_W-1:0] alpha_max_r;
  logic [gxy_pkg::LIM_W-1:0] beta_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_dist_r <= gxy_pkg::PLANE_DIST_RST;
      mirror_sp_r  <= gxy_pkg::MIRROR_SP_RST;
      alpha_max_r  <= gxy_pkg::ALPHA_MAX_RST;
      beta_max_r   <= gxy_pkg::BETA_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gxy_pkg::REG_PLANE_DIST: plane_dist_r <= cfg_data;
        gxy_pkg::REG_MIRROR_SP:  mirror_sp_r  <= cfg_data;
        gxy_pkg::REG_ALPHA_MAX:  alpha_max_r  <= cfg_data[gxy_pkg::LIM_W-1:0];
        gxy_pkg::REG_BETA_MAX:   beta_max_r   <= cfg_data[gxy_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: hold everything while a finished result waits
  logic               out_valid_r;
  gxy_pkg::out_t      out_data_r;
  logic               adv;
  gxy_pkg::pipe_ctl_t sq_ctl;
  gxy_pkg::pipe_ctl_t at_ctl;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Stage 0: capture the point together with the geometry it uses
  gxy_pkg::side_t s0_side_r;
  logic           s0_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side_r.x       <= in_data.x_pos;
      s0_side_r.y       <= in_data.y_pos;
      s0_side_r.plane_d <= plane_dist_r;
      s0_side_r.spacing <= mirror_sp_r;
      s0_side_r.amax    <= alpha_max_r;
      s0_side_r.bmax    <= beta_max_r;
    end
  end

  // Stage 1: d^2 and y^2
  logic [LW-1:0]     ay0;
  logic [2*LW-1:0]   dd_r;
  logic [2*LW-1:0]   yy_r;
  gxy_pkg::side_t    s1_side_r;
  logic              s1_v_r;

  assign ay0 = s0_side_r.y[LW-1] ? LW'(-s0_side_r.y) : LW'(s0_side_r.y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd_r      <= (2*LW)'(s0_side_r.plane_d) * (2*LW)'(s0_side_r.plane_d);
      yy_r      <= (2*LW)'(ay0) * (2*LW)'(ay0);
      s1_side_r <= s0_side_r;
    end
  end

  // Stage 2: radicand
  logic [gxy_pkg::SQ_W-1:0] rad_r;
  gxy_pkg::side_t           s2_side_r;
  logic                     s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r     <= gxy_pkg::SQ_W'(dd_r) + gxy_pkg::SQ_W'(yy_r);
      s2_side_r <= s1_side_r;
    end
  end

  // Square root of d^2 + y^2
  logic                       sq_v;
  logic [gxy_pkg::ROOT_W-1:0] sq_root;
  gxy_pkg::side_t             sq_side;

  assign sq_ctl = '{en: adv, vld: s2_v_r};

  gxy_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sq_ctl),
    .n_in     (rad_r),
    .side_in  (s2_side_r),
    .vld_out  (sq_v),
    .root_out (sq_root),
    .side_out (sq_side)
  );

  // Stage 3: alpha radius and the two arctangent jobs
  logic [LW-1:0]   ax3;
  logic [LW-1:0]   ay3;
  gxy_pkg::at_in_t a_job_r;
  gxy_pkg::at_in_t b_job_r;
  logic            s3_v_r;

  assign ax3 = sq_side.x[LW-1] ? LW'(-sq_side.x) : LW'(sq_side.x);
  assign ay3 = sq_side.y[LW-1] ? LW'(-sq_side.y) : LW'(sq_side.y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_job_r.neg <= sq_side.x[LW-1];
      a_job_r.mag <= ax3;
      a_job_r.den <= gxy_pkg::DEN_W'(sq_side.spacing) + gxy_pkg::DEN_W'(sq_root);
      a_job_r.lim <= sq_side.amax;
      b_job_r.neg <= sq_side.y[LW-1];
      b_job_r.mag <= ay3;
      b_job_r.den <= gxy_pkg::DEN_W'(sq_side.plane_d);
      b_job_r.lim <= sq_side.bmax;
    end
  end

  // Arctangent and code conversion, both mirrors in lockstep
  logic              a_v;
  logic              b_v;
  gxy_pkg::at_out_t  a_res;
  gxy_pkg::at_out_t  b_res;

  assign at_ctl = '{en: adv, vld: s3_v_r};

  gxy_atan_code u_alpha (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (at_ctl),
    .job_in  (a_job_r),
    .vld_out (a_v),
    .res_out (a_res)
  );

  gxy_atan_code u_beta (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (at_ctl),
    .job_in  (b_job_r),
    .vld_out (b_v),
    .res_out (b_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.alpha_code <= a_res.code;
      out_data_r.beta_code  <= b_res.code;
      out_data_r.clipped    <= a_res.clip || b_res.clip;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    a_v == b_v) else $error("alpha and beta units out of step");
  a_clip_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.clipped |-> out_data.alpha_code == out_data_r.alpha_code)
    else $error("output mismatch");
  a_reset_idle: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid) else $error("result after reset");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall) else $error("input taken while output held");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for galvo_xy_to_dac_codes: a point stream with checked DAC codes.
// Depends on rtl/gxy_pkg.sv and rtl/galvo_xy_to_dac_codes.sv.
`timescale 1ns / 100ps
module tb_top;

  localparam int FULL_CODE   = (1 << gxy_pkg::DAC_BITS) - 1;
  localparam int LATENCY     = 60;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gxy_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gxy_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gxy_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gxy_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Local copy of the configuration, changed only while the block is idle
  logic [gxy_pkg::LEN_W-1:0] plane_dist = gxy_pkg::PLANE_DIST_RST;
  logic [gxy_pkg::LEN_W-1:0] mirror_sp = gxy_pkg::MIRROR_SP_RST;
  logic [gxy_pkg::LIM_W-1:0] alpha_lim = gxy_pkg::ALPHA_MAX_RST;
  logic [gxy_pkg::LIM_W-1:0] beta_lim = gxy_pkg::BETA_MAX_RST;

  gxy_pkg::in_t  point_q[$];   // points waiting to be sent
  gxy_pkg::out_t codes_q[$];   // predicted codes, oldest first
  int n_sent = 0;
  int n_mismatch = 0;
  int cycles = 0;
  bit send_idle, recv_idle;
  bit in_done = 1'b0;          // a transaction was accepted at the last rising edge

  always #1 clk = ~clk;

  galvo_xy_to_dac_codes DUT (.*);

  // Exact floor square root, bit by bit
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Pade arctangent 3v*d/(v*v+3d*d) in Q2.14, truncated toward zero
  function automatic int pade_angle(longint num, longint unsigned den);
    longint unsigned mag, top, bot, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    top = (3 * mag * den) << gxy_pkg::FRAC_BITS;
    bot = mag * mag + 3 * den * den;
    if (bot == 0) return 0;
    q = top / bot;
    return (num < 0) ? -int'(q) : int'(q);
  endfunction

  // Angle to saturated code; a zero limit counts as one
  function automatic void angle_code(input int angle, input int unsigned lim,
                                     output logic [gxy_pkg::DAC_BITS-1:0] code,
                                     inout logic clip);
    longint m, t;
    longint unsigned q;
    m = (lim == 0) ? 1 : lim;
    t = angle + m;
    if (t < 0) begin
      clip = 1'b1;
      code = '0;
      return;
    end
    q = (longint'(t) << gxy_pkg::DAC_BITS) / (2 * m);
    if (q > FULL_CODE) begin
      clip = 1'b1;
      q = FULL_CODE;
    end
    code = q[gxy_pkg::DAC_BITS-1:0];
  endfunction

  function automatic gxy_pkg::out_t predict_codes(gxy_pkg::in_t p);
    longint x, y;
    longint unsigned d, ay, radius;
    gxy_pkg::out_t r;
    logic clip;
    x = p.x_pos;
    y = p.y_pos;
    d = plane_dist;
    ay = (y < 0) ? -y : y;
    radius = mirror_sp + floor_sqrt(d * d + ay * ay);
    clip = 1'b0;
    angle_code(pade_angle(x, radius), alpha_lim, r.alpha_code, clip);
    angle_code(pade_angle(y, d), beta_lim, r.beta_code, clip);
    r.clipped = clip;
    return r;
  endfunction

  // Random coordinate of random magnitude, so every bit and every scale is hit
  function automatic logic signed [gxy_pkg::LEN_W-1:0] rand_coord();
    int w;
    logic [gxy_pkg::LEN_W-1:0] v;
    w = $urandom_range(1, gxy_pkg::LEN_W);
    v = gxy_pkg::LEN_W'($urandom);
    v = v << (gxy_pkg::LEN_W - w);
    return $signed(v) >>> (gxy_pkg::LEN_W - w);
  endfunction

  // Idling profile: sender light/receiver heavy, then swapped, then none
  always @(negedge clk) begin
    if (n_sent < 500) begin
      send_idle = ($urandom_range(0, 99) < 6);
      recv_idle = ($urandom_range(0, 99) < 47);
    end else if (n_sent < 1000) begin
      send_idle = ($urandom_range(0, 99) < 47);
      recv_idle = ($urandom_range(0, 99) < 6);
    end else begin
      send_idle = 1'b0;
      recv_idle = 1'b0;
    end
    out_stall <= rst_n ? recv_idle : 1'b0;
    // Hold a stalled transaction; otherwise present the next point or go idle
    if (!in_valid || in_done) begin
      if (rst_n && point_q.size() != 0 && !send_idle) begin
        in_valid <= 1'b1;
        in_data <= point_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Accept side: predict at acceptance
  always @(posedge clk) begin
    in_done = rst_n && in_valid && !in_stall;
    if (in_done) begin
      codes_q.push_back(predict_codes(in_data));
      void'(point_q.pop_front());
      n_sent++;
    end
  end

  // Result side: compare against the oldest prediction
  always @(posedge clk) begin
    gxy_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (codes_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = codes_q.pop_front();
        if (want.alpha_code !== out_data.alpha_code ||
            want.beta_code !== out_data.beta_code ||
            want.clipped !== out_data.clipped) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
                     want.alpha_code, want.beta_code, want.clipped,
                     out_data.alpha_code, out_data.beta_code, out_data.clipped);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [gxy_pkg::CFG_IDX_W-1:0] idx,
                           logic [gxy_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gxy_pkg::REG_PLANE_DIST: plane_dist = val;
      gxy_pkg::REG_MIRROR_SP:  mirror_sp = val;
      gxy_pkg::REG_ALPHA_MAX:  alpha_lim = val[gxy_pkg::LIM_W-1:0];
      gxy_pkg::REG_BETA_MAX:   beta_lim = val[gxy_pkg::LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [23:0] d, logic [23:0] s, logic [23:0] a, logic [23:0] b);
    write_reg(gxy_pkg::REG_PLANE_DIST, d);
    write_reg(gxy_pkg::REG_MIRROR_SP, s);
    write_reg(gxy_pkg::REG_ALPHA_MAX, a);
    write_reg(gxy_pkg::REG_BETA_MAX, b);
  endtask

  // Wait for every transaction to come back, then let the pipeline empty
  task automatic drain();
    while (point_q.size() != 0 || in_valid || codes_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic queue_point(logic signed [23:0] x, logic signed [23:0] y);
    gxy_pkg::in_t p;
    p.x_pos = x;
    p.y_pos = y;
    point_q.push_back(p);
  endtask

  task automatic queue_random(int n);
    repeat (n) queue_point(rand_coord(), rand_coord());
  endtask

  task automatic queue_extremes();
    queue_point(24'sh7FFFFF, 24'sh7FFFFF);
    queue_point(-24'sh800000, -24'sh800000);
    queue_point(24'sh7FFFFF, -24'sh800000);
    queue_point(-24'sh800000, 24'sh7FFFFF);
    queue_point(0, 0);
    queue_point(1, -1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: in-range scan points and the field extremes
    queue_extremes();
    queue_point(200000, 0);
    queue_point(0, -200000);
    queue_point(20000, 20000);
    queue_random(400);
    drain();

    // Degenerate geometry: zero distance, zero spacing, zero limits, junk index
    set_config(0, 0, 0, 0);
    write_reg(3'd5, 24'hABCDEF);
    queue_extremes();
    queue_point(0, 5);
    queue_point(7, 0);
    queue_random(100);
    drain();

    // Largest values everywhere
    set_config(24'hFFFFFF, 24'hFFFFFF, 24'h7FFF, 24'h7FFF);
    write_reg(3'd7, 24'h123456);
    queue_extremes();
    queue_random(300);
    drain();

    // Random geometries
    repeat (4) begin
      set_config(24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20)),
                 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 23)),
                 24'($urandom_range(1, 32767) >> $urandom_range(0, 12)),
                 24'($urandom_range(1, 32767) >> $urandom_range(0, 12)));
      queue_random(175);
      drain();
    end

    if (n_mismatch == 0 && codes_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
